// ===== design/escape_time_fractal_iterator_assert.svh =====
// Assertion macros used by the escape-time fractal iterator core.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ETFI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("etfi: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ETFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("etfi: next-cycle check failed");

`endif

// ===== design/etfi_pkg.sv =====
// Shared types, constants and state encodings for the escape-time fractal iterator.
package etfi_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int PIXEL_BITS     = 12;
    localparam int COUNT_BITS     = 16;
    localparam int MUL_DIGIT_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_BITS      = 31;
    localparam int COORD_BITS     = 32;
    localparam int LIMIT_BITS     = 16;

    localparam logic                  MODE_RST       = 1'b0;
    localparam logic [STEP_BITS-1:0]  STEP_RST       = 31'd1048576;
    localparam logic [COORD_BITS-1:0] VIEW_LEFT_RST  = 32'hE000_0000;
    localparam logic [COORD_BITS-1:0] VIEW_TOP_RST   = 32'hE000_0000;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RST      = 16'd100;
    localparam logic [COORD_BITS-1:0] JULIA_REAL_RST = 32'h0000_0000;
    localparam logic [COORD_BITS-1:0] JULIA_IMAG_RST = 32'h0000_0000;

    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA      = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRACTAL_MODE,
        CFG_PIXEL_STEP,
        CFG_VIEW_LEFT,
        CFG_VIEW_TOP,
        CFG_ITERATION_LIMIT,
        CFG_JULIA_CONST_REAL,
        CFG_JULIA_CONST_IMAG
    } t_cfg_index;

    typedef struct packed {
        logic                  fractal_mode;
        logic [STEP_BITS-1:0]  pixel_step;
        logic [COORD_BITS-1:0] view_left;
        logic [COORD_BITS-1:0] view_top;
        logic [LIMIT_BITS-1:0] iteration_limit;
        logic [COORD_BITS-1:0] julia_const_real;
        logic [COORD_BITS-1:0] julia_const_imag;
    } t_cfg;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic                  escaped;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_X,
        S_MAP_Y,
        S_SQ_R,
        S_SQ_I,
        S_CROSS,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_ACC,
        M_SIGN
    } t_mul_state;

endpackage

// ===== design/escape_time_fractal_iterator.sv =====
// Top level of the escape-time fractal iterator: configuration registers and core.
//
// Each pixel transfer on the input channel is mapped to a complex point
// (pixel times pixel_step plus the view origin, with 0.5 added to the real part in
// Julia mode) and the block then iterates z = z*z + c until |z|^2 reaches 4 or the
// iteration limit is met, returning the iteration count and an escaped flag in one
// output transfer. All arithmetic is signed fixed point with FRAC_BITS fraction bits
// and four integer bits; products are floored and new values saturate to the format.
// Every multiplication goes through a single shared multiplier, which splits each
// operand into N = ceil(max(FRAC_BITS+4, 32) / 32) digits of 32 bits and registers
// the signed product; the sequencer takes each product before it starts the next.
// A pixel needs 3*n+4 products for n iterations. The input stalls from a transfer
// until the sequencer is back in idle, so a new pixel is taken only once the previous
// one has been iterated; the shared multiplier sets this pace. The finished result
// sits in an output register, so a new pixel is accepted while the previous result
// still waits to be taken, and the result of that new pixel is held back only if the
// output is still occupied when it is ready. Configuration writes are always accepted
// and should be made only while no pixel is in flight; writes to an unknown index are
// ignored.
module escape_time_fractal_iterator #(
    parameter int FRAC_BITS = etfi_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  etfi_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output etfi_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [etfi_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [etfi_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    etfi_pkg::t_cfg r_cfg;
    logic           cfg_xfer;

    // The register file never back-pressures the configuration channel.
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // Each register keeps only the low bits of its own width from the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fractal_mode     <= etfi_pkg::MODE_RST;
            r_cfg.pixel_step       <= etfi_pkg::STEP_RST;
            r_cfg.view_left        <= etfi_pkg::VIEW_LEFT_RST;
            r_cfg.view_top         <= etfi_pkg::VIEW_TOP_RST;
            r_cfg.iteration_limit  <= etfi_pkg::LIMIT_RST;
            r_cfg.julia_const_real <= etfi_pkg::JULIA_REAL_RST;
            r_cfg.julia_const_imag <= etfi_pkg::JULIA_IMAG_RST;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                etfi_pkg::CFG_FRACTAL_MODE: begin
                    r_cfg.fractal_mode <= i_cfg_data[0];
                end
                etfi_pkg::CFG_PIXEL_STEP: begin
                    r_cfg.pixel_step <= i_cfg_data[etfi_pkg::STEP_BITS-1:0];
                end
                etfi_pkg::CFG_VIEW_LEFT: begin
                    r_cfg.view_left <= i_cfg_data[etfi_pkg::COORD_BITS-1:0];
                end
                etfi_pkg::CFG_VIEW_TOP: begin
                    r_cfg.view_top <= i_cfg_data[etfi_pkg::COORD_BITS-1:0];
                end
                etfi_pkg::CFG_ITERATION_LIMIT: begin
                    r_cfg.iteration_limit <= i_cfg_data[etfi_pkg::LIMIT_BITS-1:0];
                end
                etfi_pkg::CFG_JULIA_CONST_REAL: begin
                    r_cfg.julia_const_real <= i_cfg_data[etfi_pkg::COORD_BITS-1:0];
                end
                etfi_pkg::CFG_JULIA_CONST_IMAG: begin
                    r_cfg.julia_const_imag <= i_cfg_data[etfi_pkg::COORD_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The core holds the sequencer, the shared multiplier and the output register.
    etfi_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/etfi_mul.sv =====
// Shared signed multiplier that accumulates digit partial products one digit pair at a time.
module etfi_mul #(
    parameter int OP_BITS = etfi_pkg::COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [OP_BITS-1:0]     i_a,
    input  logic signed [OP_BITS-1:0]     i_b,
    output logic                          o_done,
    output logic signed [2*OP_BITS-1:0]   o_prod
);

    localparam int DIG  = etfi_pkg::MUL_DIGIT_BITS;
    localparam int NDIG = (OP_BITS + DIG - 1) / DIG;
    localparam int PAD  = NDIG * DIG;
    localparam int ACCW = 2 * PAD;
    localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int PRW  = 2 * OP_BITS;

    etfi_pkg::t_mul_state r_state, n_state;
    logic [PAD-1:0]       r_a_mag, r_b_mag;
    logic                 r_neg;
    logic [IW-1:0]        r_i, r_j;
    logic [ACCW-1:0]      r_acc;
    logic signed [PRW-1:0] r_prod;
    logic                 r_done;

    logic [OP_BITS-1:0]   a_abs, b_abs;
    logic [DIG-1:0]       a_dig, b_dig;
    logic [2*DIG-1:0]     pp;
    logic [IW:0]          dig_sum;
    logic [ACCW-1:0]      pp_sh;
    logic [PRW-1:0]       acc_lo;
    logic                 last_step;
    logic                 do_load, do_acc, do_sign;

    // Magnitudes of the operands; the most negative value still fits unsigned.
    assign a_abs = i_a[OP_BITS-1] ? (~i_a + OP_BITS'(1)) : i_a;
    assign b_abs = i_b[OP_BITS-1] ? (~i_b + OP_BITS'(1)) : i_b;

    assign a_dig     = r_a_mag[r_i*DIG +: DIG];
    assign b_dig     = r_b_mag[r_j*DIG +: DIG];
    assign pp        = a_dig * b_dig;
    assign dig_sum   = {1'b0, r_i} + {1'b0, r_j};
    assign pp_sh     = ACCW'(pp) << (dig_sum * DIG);
    assign acc_lo    = r_acc[PRW-1:0];
    assign last_step = (r_i == IW'(NDIG - 1)) && (r_j == IW'(NDIG - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            etfi_pkg::M_IDLE: begin
                if (i_start) begin
                    n_state = etfi_pkg::M_ACC;
                end
            end
            etfi_pkg::M_ACC: begin
                if (last_step) begin
                    n_state = etfi_pkg::M_SIGN;
                end
            end
            etfi_pkg::M_SIGN: begin
                n_state = etfi_pkg::M_IDLE;
            end
            default: begin
                n_state = etfi_pkg::M_IDLE;
            end
        endcase
    end

    always_comb begin
        do_load = 1'b0;
        do_acc  = 1'b0;
        do_sign = 1'b0;
        unique case (r_state)
            etfi_pkg::M_IDLE: begin
                do_load = i_start;
            end
            etfi_pkg::M_ACC: begin
                do_acc = 1'b1;
            end
            etfi_pkg::M_SIGN: begin
                do_sign = 1'b1;
            end
            default: begin
                do_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etfi_pkg::M_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= do_sign;
            if (do_load) begin
                r_i <= '0;
                r_j <= '0;
            end else if (do_acc) begin
                if (r_j == IW'(NDIG - 1)) begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_a_mag <= PAD'(a_abs);
            r_b_mag <= PAD'(b_abs);
            r_neg   <= i_a[OP_BITS-1] ^ i_b[OP_BITS-1];
            r_acc   <= '0;
        end else if (do_acc) begin
            r_acc <= r_acc + pp_sh;
        end
        if (do_sign) begin
            r_prod <= r_neg ? $signed(-acc_lo) : $signed(acc_lo);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== design/etfi_core.sv =====
// Sequencer and datapath that maps a pixel and runs the escape-time iteration.
`include "escape_time_fractal_iterator_assert.svh"

module etfi_core #(
    parameter int FRAC_BITS = etfi_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etfi_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  etfi_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output etfi_pkg::t_out_item o_out_data
);

    localparam int W   = FRAC_BITS + 4;
    localparam int MW  = (W > etfi_pkg::COORD_BITS) ? W : etfi_pkg::COORD_BITS;
    localparam int PRW = 2 * MW;
    localparam int PW  = PRW + 1;
    localparam int SW  = W + 6;

    localparam logic signed [PW-1:0] FMT_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] FMT_MIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF    = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] FOUR    = SW'(4) <<< FRAC_BITS;

    function automatic logic signed [W-1:0] f_sat(input logic signed [PW-1:0] v);
        logic signed [W-1:0] res;
        if (v > FMT_MAX) begin
            res = FMT_MAX[W-1:0];
        end else if (v < FMT_MIN) begin
            res = FMT_MIN[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    etfi_pkg::t_state r_state, n_state;
    logic                                r_pending;
    logic [etfi_pkg::PIXEL_BITS-1:0]     r_px, r_py;
    logic [etfi_pkg::COUNT_BITS-1:0]     r_limit, r_count;
    logic signed [W-1:0]                 r_zr, r_zi, r_cr, r_ci;
    logic signed [SW-1:0]                r_sr, r_diff;
    logic                                r_esc;
    logic                                r_out_valid;
    etfi_pkg::t_out_item                 r_out;

    logic                                mul_start, mul_done;
    logic signed [MW-1:0]                mul_a, mul_b;
    logic signed [PRW-1:0]               mul_prod;

    logic                                in_xfer, out_free, julia;
    logic signed [SW-1:0]                prod_sq, prod_cross, mag;
    logic                                esc_now, stop_now;
    logic signed [PW-1:0]                map_view, map_sum;
    logic signed [W-1:0]                 map_sat, jr_sat, ji_sat, zr_next, zi_next;

    etfi_mul #(
        .OP_BITS (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign julia    = (i_cfg.fractal_mode == etfi_pkg::MODE_JULIA);
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Products are floored by the arithmetic shift; the cross term keeps one more bit.
    assign prod_sq    = SW'(mul_prod >>> FRAC_BITS);
    assign prod_cross = SW'(mul_prod >>> (FRAC_BITS - 1));
    assign mag        = r_sr + prod_sq;
    assign esc_now    = (mag >= FOUR);
    assign stop_now   = esc_now || (r_count >= r_limit);

    assign map_view = (r_state == etfi_pkg::S_MAP_X) ? PW'($signed(i_cfg.view_left))
                                                     : PW'($signed(i_cfg.view_top));
    assign map_sum  = PW'(mul_prod) + map_view
                    + (((r_state == etfi_pkg::S_MAP_X) && julia) ? HALF : PW'(0));
    assign map_sat  = f_sat(map_sum);
    assign jr_sat   = f_sat(PW'($signed(i_cfg.julia_const_real)));
    assign ji_sat   = f_sat(PW'($signed(i_cfg.julia_const_imag)));
    assign zr_next  = f_sat(PW'(r_diff) + PW'(r_cr));
    assign zi_next  = f_sat(PW'(prod_cross) + PW'(r_ci));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            etfi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = etfi_pkg::S_MAP_X;
                end
            end
            etfi_pkg::S_MAP_X: begin
                if (mul_done) begin
                    n_state = etfi_pkg::S_MAP_Y;
                end
            end
            etfi_pkg::S_MAP_Y: begin
                if (mul_done) begin
                    n_state = etfi_pkg::S_SQ_R;
                end
            end
            etfi_pkg::S_SQ_R: begin
                if (mul_done) begin
                    n_state = etfi_pkg::S_SQ_I;
                end
            end
            etfi_pkg::S_SQ_I: begin
                if (mul_done) begin
                    n_state = stop_now ? etfi_pkg::S_DONE : etfi_pkg::S_CROSS;
                end
            end
            etfi_pkg::S_CROSS: begin
                if (mul_done) begin
                    n_state = etfi_pkg::S_SQ_R;
                end
            end
            etfi_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = etfi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = etfi_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        mul_start  = 1'b0;
        mul_a      = MW'(r_zr);
        mul_b      = MW'(r_zr);
        unique case (r_state)
            etfi_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            etfi_pkg::S_MAP_X: begin
                mul_start = !r_pending;
                mul_a     = $signed(MW'(r_px));
                mul_b     = $signed(MW'(i_cfg.pixel_step));
            end
            etfi_pkg::S_MAP_Y: begin
                mul_start = !r_pending;
                mul_a     = $signed(MW'(r_py));
                mul_b     = $signed(MW'(i_cfg.pixel_step));
            end
            etfi_pkg::S_SQ_R: begin
                mul_start = !r_pending;
            end
            etfi_pkg::S_SQ_I: begin
                mul_start = !r_pending;
                mul_a     = MW'(r_zi);
                mul_b     = MW'(r_zi);
            end
            etfi_pkg::S_CROSS: begin
                mul_start = !r_pending;
                mul_b     = MW'(r_zi);
            end
            etfi_pkg::S_DONE: begin
                o_in_stall = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etfi_pkg::S_IDLE;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mul_start) begin
                r_pending <= 1'b1;
            end else if (mul_done) begin
                r_pending <= 1'b0;
            end
            if ((r_state == etfi_pkg::S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_px    <= i_in_data.pixel_x;
            r_py    <= i_in_data.pixel_y;
            r_limit <= i_cfg.iteration_limit[etfi_pkg::COUNT_BITS-1:0];
        end
        if (mul_done) begin
            unique case (r_state)
                etfi_pkg::S_MAP_X: begin
                    if (julia) begin
                        r_zr <= map_sat;
                    end else begin
                        r_cr <= map_sat;
                    end
                end
                etfi_pkg::S_MAP_Y: begin
                    r_count <= '0;
                    if (julia) begin
                        r_zi <= map_sat;
                        r_cr <= jr_sat;
                        r_ci <= ji_sat;
                    end else begin
                        r_ci <= map_sat;
                        r_zr <= '0;
                        r_zi <= '0;
                    end
                end
                etfi_pkg::S_SQ_R: begin
                    r_sr <= prod_sq;
                end
                etfi_pkg::S_SQ_I: begin
                    r_esc  <= esc_now;
                    r_diff <= r_sr - prod_sq;
                end
                etfi_pkg::S_CROSS: begin
                    r_zr    <= zr_next;
                    r_zi    <= zi_next;
                    r_count <= r_count + etfi_pkg::COUNT_BITS'(1);
                end
                default: begin
                    r_sr <= r_sr;
                end
            endcase
        end
        if ((r_state == etfi_pkg::S_DONE) && out_free) begin
            r_out.iteration_count <= r_count;
            r_out.escaped         <= r_esc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ETFI_ASSERT_IMPLY(a_done_only_when_pending, i_clk, i_rst_n, mul_done, r_pending)
    `ETFI_ASSERT_NEXT(a_accept_starts_map, i_clk, i_rst_n, in_xfer, r_state == etfi_pkg::S_MAP_X)
    `ETFI_ASSERT_IMPLY(a_count_within_limit, i_clk, i_rst_n, (r_state == etfi_pkg::S_SQ_R) || (r_state == etfi_pkg::S_SQ_I) || (r_state == etfi_pkg::S_CROSS), r_count <= r_limit)
    `ETFI_ASSERT_IMPLY(a_stop_has_reason, i_clk, i_rst_n, r_state == etfi_pkg::S_DONE, r_esc || (r_count == r_limit))

endmodule
